/* design/jpp_pkg.sv */
package jpp_pkg;

  localparam int DEPTH_W     = 7;
  localparam int TAB_W       = 4;
  localparam int PAD_W       = 10;
  localparam int PROD_W      = DEPTH_W + TAB_W;
  localparam int MAX_DEPTH_D = 64;
  localparam int QUEUE_D     = 2;

  localparam logic [TAB_W-1:0] TAB_RESET = 4'd2;
  localparam logic [PAD_W-1:0] PAD_MAX   = 10'h3FF;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       doc_start;
  } jpp_in_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [PAD_W-1:0] pad_spaces;
    logic             run_last;
  } jpp_out_t;

  // One classified input byte: one or two result bytes, pad on one of them.
  typedef struct packed {
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic [PAD_W-1:0] pad;
    logic             two;
    logic             pad_first;
  } jpp_cmd_t;

  localparam int CMD_W = $bits(jpp_cmd_t);

endpackage

/* design/jpp_front.sv */
module jpp_front import jpp_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_D
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  jpp_in_t          in_data,
  input  logic [TAB_W-1:0] tab_width,
  output logic             push,
  output jpp_cmd_t         cmd
);

  localparam logic [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(MAX_DEPTH);

  logic               inside_string;
  logic               inside_string_next;
  logic [DEPTH_W-1:0] nest_depth;
  logic [DEPTH_W-1:0] nest_depth_next;
  logic               cur_str;
  logic [DEPTH_W-1:0] cur_depth;
  logic [PROD_W-1:0]  prod;
  logic               drop;
  logic [7:0]         c;

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_string <= 1'b0;
      nest_depth    <= '0;
    end else if (accept) begin
      inside_string <= inside_string_next;
      nest_depth    <= nest_depth_next;
    end
  end

  always_comb begin
    c         = in_data.in_byte;
    cur_str   = in_data.doc_start ? 1'b0 : inside_string;
    cur_depth = in_data.doc_start ? '0 : nest_depth;
    inside_string_next = cur_str;
    nest_depth_next    = cur_depth;
    drop          = 1'b0;
    cmd.byte0     = c;
    cmd.byte1     = c;
    cmd.two       = 1'b0;
    cmd.pad_first = 1'b0;
    if (c == CH_QUOTE) begin
      inside_string_next = ~cur_str;
    end else if (!cur_str) begin
      case (c)
        CH_LBRACE, CH_LBRACK: begin
          if (cur_depth < DEPTH_TOP) nest_depth_next = cur_depth + 1'b1;
          cmd.byte1 = CH_LF;
          cmd.two   = 1'b1;
        end
        CH_RBRACE, CH_RBRACK: begin
          if (cur_depth != '0) nest_depth_next = cur_depth - 1'b1;
          cmd.byte0     = CH_LF;
          cmd.two       = 1'b1;
          cmd.pad_first = 1'b1;
        end
        CH_COMMA: begin
          cmd.byte1 = CH_LF;
          cmd.two   = 1'b1;
        end
        CH_COLON: begin
          cmd.byte1 = CH_SPACE;
          cmd.two   = 1'b1;
        end
        CH_SPACE, CH_TAB, CH_LF, CH_CR: drop = 1'b1;
        default: ;
      endcase
    end
    // pad goes only with a newline; colon case keeps byte1 a space, pad cleared below
    prod = {{TAB_W{1'b0}}, nest_depth_next} * {{DEPTH_W{1'b0}}, tab_width};
    if (prod > PROD_W'(PAD_MAX)) cmd.pad = PAD_MAX;
    else                         cmd.pad = prod[PAD_W-1:0];
    if (!cur_str && c == CH_COLON) cmd.pad = '0;
    push = accept && !drop;
  end

endmodule

/* design/jpp_queue.sv */
module jpp_queue import jpp_pkg::*; #(
  parameter int DEPTH = QUEUE_D
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  jpp_cmd_t wdata,
  input  logic     pop,
  output logic     full,
  output logic     empty,
  output jpp_cmd_t rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH - 1);

  jpp_cmd_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_TOP) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_TOP) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* design/jpp_back.sv */
module jpp_back import jpp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  jpp_cmd_t q_data,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output jpp_out_t out_data
);

  logic     phase;
  logic     load;
  logic     last;
  jpp_out_t res;

  always_comb begin
    load = !q_empty && (!out_valid || out_ready);
    last = !q_data.two || phase;
    if (!phase) begin
      res.out_byte   = q_data.byte0;
      res.pad_spaces = (q_data.two && q_data.pad_first) ? q_data.pad : '0;
    end else begin
      res.out_byte   = q_data.byte1;
      res.pad_spaces = q_data.pad_first ? '0 : q_data.pad;
    end
    res.run_last = last;
    pop = load && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= res;
  end

endmodule

/* design/json_pretty_print_stream.sv */
// A result is registered first in the command queue, then in the output register.
// Throughput: one result per cycle out of the output stage while out_ready holds; a byte
//   giving two results holds that stage for both, and its command is popped only with the second.
// Input is taken whenever the two-entry command queue has room.
// Reset (rst, synchronous): depth and string flag cleared, queue and output emptied,
//   tab_width back to 2.
module json_pretty_print_stream import jpp_pkg::*; #(
  parameter int MAX_DEPTH   = MAX_DEPTH_D,
  parameter int QUEUE_DEPTH = QUEUE_D
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  jpp_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output jpp_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TAB_W-1:0] cfg_data
);

  logic [TAB_W-1:0] tab_width;
  logic             accept;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  jpp_cmd_t         cmd_in;
  jpp_cmd_t         cmd_out;

  // Config transfer always taken; the user must write it only while the stream is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width <= TAB_RESET;
    end else if (cfg_valid) begin
      tab_width <= cfg_data;
    end
  end

  // Front side stalls only on a full queue; whitespace is taken and dropped.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  jpp_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_data   (in_data),
    .tab_width (tab_width),
    .push      (push),
    .cmd       (cmd_in)
  );

  jpp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .pop   (pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (cmd_out)
  );

  // Back side expands each command into one or two output transfers.
  jpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (cmd_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* bench/json_pretty_print_stream_tb.sv */
`timescale 1ns / 100ps

module json_pretty_print_stream_tb;
  import jpp_pkg::*;

  localparam int LIMIT_CYCLES   = 400000;
  localparam int RAND_PER_PHASE = 165;   // non-whitespace bytes per phase
  localparam int NUM_PHASES     = 8;
  localparam int SETTLE_CYCLES  = 8;     // settle time after the last predicted byte is out
  localparam int PRED           = -1;    // table row checked by the predictor

  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_HIGH   = 8'hFF;

  // One directed row: the byte to send and, where it is obvious, what must come out.
  typedef struct {
    jpp_in_t  stim;
    int       n;
    jpp_out_t r0;
    jpp_out_t r1;
  } dir_row_t;

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  jpp_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  jpp_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TAB_W-1:0] cfg_data  = '0;

  // Predictor state: string flag, nesting depth and the tab width.
  logic               fmt_in_str = 1'b0;
  logic [DEPTH_W-1:0] fmt_depth  = '0;
  logic [TAB_W-1:0]   fmt_tab    = TAB_RESET;

  jpp_out_t pretty_q[$];   // pretty-printed bytes still to come out, oldest first
  dir_row_t dir_rows[$];

  int          errors   = 0;
  int          accepted = 0;
  int          cycles   = 0;
  int unsigned gap_pct   = 0;   // sender idle chance per cycle, percent
  int unsigned stall_pct = 0;   // receiver stall chance per cycle, percent

  json_pretty_print_stream u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------

  function automatic jpp_out_t res(logic [7:0] b, logic [PAD_W-1:0] p, logic l);
    return {b, p, l};
  endfunction

  // Indent after a newline: depth times tab width, clamped to the pad field.
  function automatic logic [PAD_W-1:0] indent_now();
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(fmt_depth) * PROD_W'(fmt_tab);
    return (prod > PROD_W'(PAD_MAX)) ? PAD_MAX : prod[PAD_W-1:0];
  endfunction

  // Advances the formatter state by one byte; returns how many bytes it yields.
  function automatic int pretty_step(input jpp_in_t it, output jpp_out_t r0,
                                     output jpp_out_t r1);
    logic [7:0] c;
    int         n;
    c  = it.in_byte;
    r0 = '0;
    r1 = '0;
    n  = 0;
    if (it.doc_start) begin
      fmt_depth  = '0;
      fmt_in_str = 1'b0;
    end
    if (c == CH_QUOTE) begin
      // quote always toggles; a backslash before it does not matter
      fmt_in_str = ~fmt_in_str;
      r0 = res(c, '0, 1'b1);
      n  = 1;
    end else if (fmt_in_str) begin
      r0 = res(c, '0, 1'b1);
      n  = 1;
    end else begin
      case (c)
        CH_LBRACE, CH_LBRACK: begin
          if (fmt_depth < DEPTH_W'(MAX_DEPTH_D)) fmt_depth = fmt_depth + 1'b1;
          r0 = res(c, '0, 1'b0);
          r1 = res(CH_LF, indent_now(), 1'b1);
          n  = 2;
        end
        CH_RBRACE, CH_RBRACK: begin
          if (fmt_depth != '0) fmt_depth = fmt_depth - 1'b1;
          r0 = res(CH_LF, indent_now(), 1'b0);
          r1 = res(c, '0, 1'b1);
          n  = 2;
        end
        CH_COMMA: begin
          r0 = res(c, '0, 1'b0);
          r1 = res(CH_LF, indent_now(), 1'b1);
          n  = 2;
        end
        CH_COLON: begin
          r0 = res(c, '0, 1'b0);
          r1 = res(CH_SPACE, '0, 1'b1);
          n  = 2;
        end
        CH_SPACE, CH_TAB, CH_LF, CH_CR: n = 0;   // dropped outside strings
        default: begin
          r0 = res(c, '0, 1'b1);
          n  = 1;
        end
      endcase
    end
    return n;
  endfunction

  //--------------------------------------------------------------------------
  // Scoreboard: predicts on every input transfer, checks every output transfer.
  // Directed rows with typed expectations replace the predicted bytes, while
  // the predictor still runs so its state stays in step.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    jpp_out_t p0, p1, want;
    int       n;
    if (!rst) begin
      if (cfg_valid && cfg_ready) fmt_tab = cfg_data;
      if (in_valid && in_ready) begin
        n = pretty_step(in_data, p0, p1);
        if (accepted < dir_rows.size() && dir_rows[accepted].n != PRED) begin
          n  = dir_rows[accepted].n;
          p0 = dir_rows[accepted].r0;
          p1 = dir_rows[accepted].r1;
        end
        if (n > 0) pretty_q.push_back(p0);
        if (n > 1) pretty_q.push_back(p1);
        accepted++;
      end
      if (out_valid && out_ready) begin
        if (pretty_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output: expected nothing, got byte=%02h pad=%0d last=%0b",
                   $time, out_data.out_byte, out_data.pad_spaces, out_data.run_last);
        end else begin
          want = pretty_q.pop_front();
          if (out_data !== want) begin
            errors++;
            $display("%0t: mismatch: expected byte=%02h pad=%0d last=%0b",
                     $time, want.out_byte, want.pad_spaces, want.run_last);
            $display("%0t:           got byte=%02h pad=%0d last=%0b",
                     $time, out_data.out_byte, out_data.pad_spaces, out_data.run_last);
          end
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Stimulus helpers
  //--------------------------------------------------------------------------

  // n == PRED: predictor decides; else up to two typed bytes, last flag on the final one.
  function automatic void dir_add(logic [7:0] b, logic ds, int n,
                                  logic [7:0] b0 = 8'h00, int p0 = 0,
                                  logic [7:0] b1 = 8'h00, int p1 = 0);
    dir_row_t row;
    row.stim = {b, ds};
    row.n    = n;
    row.r0   = res(b0, PAD_W'(p0), n == 1);
    row.r1   = res(b1, PAD_W'(p1), 1'b1);
    dir_rows.push_back(row);
  endfunction

  // Optional idle gap, then hold valid and payload until the transfer.
  task automatic send_byte(input jpp_in_t d);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending, wait for every predicted byte, then let the pipe settle
  // (whitespace leaves nothing to wait for but may still be in flight).
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pretty_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tab(input logic [TAB_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly JSON tokens with random text, some stray bytes and restarts.
  function automatic jpp_in_t rand_item();
    jpp_in_t     it;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12)      it.in_byte = $urandom_range(1) ? CH_LBRACE : CH_LBRACK;
    else if (r < 24) it.in_byte = $urandom_range(1) ? CH_RBRACE : CH_RBRACK;
    else if (r < 34) it.in_byte = CH_COMMA;
    else if (r < 42) it.in_byte = CH_COLON;
    else if (r < 54) it.in_byte = CH_QUOTE;
    else if (r < 62) begin
      case ($urandom_range(3))
        0:       it.in_byte = CH_SPACE;
        1:       it.in_byte = CH_TAB;
        2:       it.in_byte = CH_LF;
        default: it.in_byte = CH_CR;
      endcase
    end
    else if (r < 90) it.in_byte = 8'($urandom_range(126, 32));
    else             it.in_byte = 8'($urandom);
    it.doc_start = ($urandom_range(99) < 3);
    return it;
  endfunction

  // Climb past the depth limit, then unwind below zero.
  task automatic send_dive();
    jpp_in_t it;
    int      levels;
    levels = $urandom_range(72, 66);
    for (int i = 0; i < levels; i++) begin
      it.in_byte   = $urandom_range(1) ? CH_LBRACE : CH_LBRACK;
      it.doc_start = (i == 0);
      send_byte(it);
    end
    for (int i = 0; i < levels + 2; i++) begin
      it.in_byte   = $urandom_range(1) ? CH_RBRACE : CH_RBRACK;
      it.doc_start = 1'b0;
      send_byte(it);
    end
  endtask

  //--------------------------------------------------------------------------
  // Main sequence
  //--------------------------------------------------------------------------
  initial begin : stimulus
    jpp_in_t it;
    int      counted;
    bit      held;

    // Directed table, tab width at its reset value of 2.
    dir_add(CH_SPACE,  1'b0, 0);                                 // dropped right after reset
    dir_add(CH_LBRACE, 1'b1, 2, CH_LBRACE, 0, CH_LF, 2);
    dir_add(CH_QUOTE,  1'b0, 1, CH_QUOTE);                       // enter string
    dir_add(CH_A,      1'b0, PRED);
    dir_add(CH_BSLASH, 1'b0, PRED);                              // no escape meaning
    dir_add(CH_QUOTE,  1'b0, PRED);                              // closes the string anyway
    dir_add(CH_COLON,  1'b0, 2, CH_COLON, 0, CH_SPACE, 0);
    dir_add(CH_SPACE,  1'b0, 0);
    dir_add(CH_NUL,    1'b0, 1, CH_NUL);                         // NUL passes through
    dir_add(CH_HIGH,   1'b0, 1, CH_HIGH);
    dir_add(CH_COMMA,  1'b0, 2, CH_COMMA, 0, CH_LF, 2);
    dir_add(CH_LBRACK, 1'b0, 2, CH_LBRACK, 0, CH_LF, 4);
    dir_add(CH_RBRACK, 1'b0, 2, CH_LF, 2, CH_RBRACK, 0);
    dir_add(CH_RBRACE, 1'b0, 2, CH_LF, 0, CH_RBRACE, 0);
    dir_add(CH_RBRACE, 1'b0, 2, CH_LF, 0, CH_RBRACE, 0);         // underflow, depth stays 0
    dir_add(CH_RBRACK, 1'b0, 2, CH_LF, 0, CH_RBRACK, 0);
    dir_add(CH_TAB,    1'b0, 0);
    dir_add(CH_CR,     1'b0, 0);
    dir_add(CH_LF,     1'b0, 0);
    dir_add(CH_QUOTE,  1'b0, 1, CH_QUOTE);
    dir_add(CH_SPACE,  1'b0, PRED);                              // whitespace kept in string
    dir_add(CH_LF,     1'b0, PRED);
    dir_add(CH_LBRACE, 1'b0, PRED);                              // bracket is plain text here
    dir_add(CH_LBRACK, 1'b1, 2, CH_LBRACK, 0, CH_LF, 2);         // restart clears string flag
    dir_add(CH_QUOTE,  1'b1, 1, CH_QUOTE);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].stim);

    // Random phases: each with its own tab width and idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       ;                                 // keep reset tab width
        1:       set_tab(4'd0);
        2:       set_tab(4'd8);
        3:       set_tab(4'd15);
        6:       set_tab(4'd1);
        7:       set_tab(4'd15);
        default: set_tab(TAB_W'($urandom_range(15)));
      endcase
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 81; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 81; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase

      counted = 0;
      held    = 1'b0;
      while (counted < RAND_PER_PHASE) begin
        it = rand_item();
        send_byte(it);
        if (!(it.in_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})) counted++;
        // once: sender holds off until the output has fully drained
        if (p == 2 && !held && counted >= RAND_PER_PHASE / 2) begin
          held = 1'b1;
          wait_idle();
        end
      end
      if (p % 2 == 1) send_dive();
    end

    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
